>>> rtl/ihsr_pkg.sv
// Shared types, codes and helper functions of the I2C humidity sensor reader.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ihsr_pkg;

	// Bus phase codes of the bit-level sequencer.
	localparam logic [4:0] PH_IDLE = 5'd0;
	localparam logic [4:0] PH_ST_A = 5'd1;
	localparam logic [4:0] PH_ST_B = 5'd2;
	localparam logic [4:0] PH_ST_C = 5'd3;
	localparam logic [4:0] PH_ST_D = 5'd4;
	localparam logic [4:0] PH_WB_L = 5'd5;
	localparam logic [4:0] PH_WB_H = 5'd6;
	localparam logic [4:0] PH_WA_L = 5'd7;
	localparam logic [4:0] PH_WA_H = 5'd8;
	localparam logic [4:0] PH_RB_L = 5'd9;
	localparam logic [4:0] PH_RB_H = 5'd10;
	localparam logic [4:0] PH_MA_L = 5'd11;
	localparam logic [4:0] PH_MA_H = 5'd12;
	localparam logic [4:0] PH_SP_A = 5'd13;
	localparam logic [4:0] PH_SP_B = 5'd14;
	localparam logic [4:0] PH_SP_C = 5'd15;
	localparam logic [4:0] PH_POLL = 5'd16;

	// Transaction script operations.
	typedef enum logic [3:0] {
		OP_END   = 4'd0,
		OP_START = 4'd1,
		OP_WADDR = 4'd2,
		OP_WCMD  = 4'd3,
		OP_WVAL  = 4'd4,
		OP_RADDR = 4'd5,
		OP_RPOLL = 4'd6,
		OP_RACK  = 4'd7,
		OP_RNACK = 4'd8,
		OP_STOP  = 4'd9,
		OP_WAIT  = 4'd10
	} op_t;

	// Flow codes of a start request.
	localparam logic [2:0] FLOW_HOLD    = 3'd0;
	localparam logic [2:0] FLOW_POLLED  = 3'd1;
	localparam logic [2:0] FLOW_RD_BYTE = 3'd2;
	localparam logic [2:0] FLOW_WR_BYTE = 3'd3;
	localparam logic [2:0] FLOW_CMD     = 3'd4;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_BUS_ADDRESS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_POLL_WAIT   = 2'd2;
	localparam int unsigned CFG_DATA_W = 24;

	// Register reset values.
	localparam logic [6:0]  BUS_ADDRESS_RST = 7'd64;
	localparam logic [15:0] HALF_PERIOD_RST = 16'd250;
	localparam logic [23:0] POLL_WAIT_RST   = 24'd40000;

	// Conversion constants: scale factors in 1/65536 units and offsets in hundredths.
	localparam logic [15:0] STATUS_MASK  = 16'hFFFC;
	localparam logic [14:0] TEMP_SCALE   = 15'd17572;
	localparam logic [14:0] HUM_SCALE    = 15'd12500;
	localparam logic [14:0] TEMP_OFFSET  = 15'd4685;
	localparam logic [14:0] HUM_OFFSET   = 15'd600;
	localparam logic [30:0] ROUND_HALF   = 31'd32768;

	// Bound on the script positions of every flow.
	localparam logic [3:0] SCRIPT_LEN = 4'd10;

	// Operation at a given script position of a flow.
	function automatic op_t script_op(input logic [2:0] flow, input logic [3:0] stage);
		op_t op;
		op = OP_END;
		if (stage < SCRIPT_LEN) begin
			case (flow)
				FLOW_HOLD: begin
					case (stage)
						4'd0: op = OP_START;
						4'd1: op = OP_WADDR;
						4'd2: op = OP_WCMD;
						4'd3: op = OP_START;
						4'd4: op = OP_RADDR;
						4'd5: op = OP_RACK;
						4'd6: op = OP_RNACK;
						4'd7: op = OP_STOP;
						default: op = OP_END;
					endcase
				end
				FLOW_POLLED: begin
					case (stage)
						4'd0: op = OP_START;
						4'd1: op = OP_WADDR;
						4'd2: op = OP_WCMD;
						4'd3: op = OP_WAIT;
						4'd4: op = OP_START;
						4'd5: op = OP_RPOLL;
						4'd6: op = OP_RACK;
						4'd7: op = OP_RNACK;
						4'd8: op = OP_STOP;
						default: op = OP_END;
					endcase
				end
				FLOW_RD_BYTE: begin
					case (stage)
						4'd0: op = OP_START;
						4'd1: op = OP_WADDR;
						4'd2: op = OP_WCMD;
						4'd3: op = OP_START;
						4'd4: op = OP_RADDR;
						4'd5: op = OP_RNACK;
						4'd6: op = OP_STOP;
						default: op = OP_END;
					endcase
				end
				FLOW_WR_BYTE: begin
					case (stage)
						4'd0: op = OP_START;
						4'd1: op = OP_WADDR;
						4'd2: op = OP_WCMD;
						4'd3: op = OP_WVAL;
						4'd4: op = OP_STOP;
						default: op = OP_END;
					endcase
				end
				FLOW_CMD: begin
					case (stage)
						4'd0: op = OP_START;
						4'd1: op = OP_WADDR;
						4'd2: op = OP_WCMD;
						4'd3: op = OP_STOP;
						default: op = OP_END;
					endcase
				end
				default: op = OP_END;
			endcase
		end
		return op;
	endfunction

	// Line drives of a phase: bit 1 releases SCL, bit 0 releases SDA.
	function automatic logic [1:0] phase_drive(input logic [4:0] phase, input logic data_msb,
		input op_t op);
		logic [1:0] d;
		logic       nack;
		nack = (op == OP_RNACK);
		case (phase)
			PH_ST_A: d = 2'b01;
			PH_ST_B: d = 2'b11;
			PH_ST_C: d = 2'b10;
			PH_ST_D: d = 2'b00;
			PH_WB_L: d = {1'b0, data_msb};
			PH_WB_H: d = {1'b1, data_msb};
			PH_WA_L: d = 2'b01;
			PH_RB_L: d = 2'b01;
			PH_WA_H: d = 2'b11;
			PH_RB_H: d = 2'b11;
			PH_MA_L: d = {1'b0, nack};
			PH_MA_H: d = {1'b1, nack};
			PH_SP_A: d = 2'b00;
			PH_SP_B: d = 2'b10;
			PH_SP_C: d = 2'b11;
			PH_POLL: d = 2'b01;
			default: d = 2'b11;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ihsr_if.sv
// Channel interfaces of the I2C humidity sensor reader: tick/request words in,
// result words out, and the configuration write channel. Depends on ihsr_pkg.
`default_nettype none

// Input channel: one tick or start request per word.
interface ihsr_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [2:0] flow;
	logic [7:0] command_byte;
	logic [7:0] write_value;
	logic       quantity;
	logic       sda_level;
	logic       scl_level;

	modport source (output valid, req_type, flow, command_byte, write_value, quantity,
		sda_level, scl_level, input ready);
	modport sink (input valid, req_type, flow, command_byte, write_value, quantity,
		sda_level, scl_level, output ready);
endinterface

// Output channel: one result word per accepted input word.
interface ihsr_out_if;
	logic               valid;
	logic               ready;
	logic               scl_release;
	logic               sda_release;
	logic               busy_res;
	logic               done_res;
	logic               ack_fail;
	logic [15:0]        raw_value;
	logic [7:0]         read_byte;
	logic signed [14:0] scaled_centi;

	modport source (output valid, scl_release, sda_release, busy_res, done_res, ack_fail,
		raw_value, read_byte, scaled_centi, input ready);
	modport sink (input valid, scl_release, sda_release, busy_res, done_res, ack_fail,
		raw_value, read_byte, scaled_centi, output ready);
endinterface

// Configuration write channel.
interface ihsr_cfg_if import ihsr_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/i2c_humidity_sensor_reader_unit.sv
// Top level of the I2C humidity sensor reader: transaction sequencer, conversion
// and result register. Depends on ihsr_pkg and the interfaces in ihsr_if.sv.
//
// Usage:
//   in_ch  carries one word per time tick (req_type 0) with the sampled SDA and
//          SCL levels, or a start request (req_type 1) naming the flow.
//   out_ch returns exactly one result word per accepted input word, in order:
//          line releases, busy, done, ack error, raw, read byte and the value
//          converted to hundredths of a degree or percent.
//   cfg    writes bus address (index 0), half period (1) and poll wait (2);
//          it is always ready and takes effect at once.
// Timing: the whole step of the sequencer and the conversion
// happen in the cycle a word is accepted; its result is registered and valid in the next cycle.
// One word is accepted every clock, limited only by the single output register.
// If the receiver stalls, the result register holds and in_ch.ready drops until
// the result is taken; an accepted word is never lost.
// Reset: the sequencer returns to idle with cleared state, the registers load
// address 64, half period 250 and poll wait 40000, and no result is pending.
`default_nettype none

module i2c_humidity_sensor_reader_unit import ihsr_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	ihsr_in_if.sink    in_ch,
	ihsr_out_if.source out_ch,
	ihsr_cfg_if.sink   cfg
);

	// Configuration registers.
	logic [6:0]  bus_address_q;
	logic [15:0] half_period_q;
	logic [23:0] poll_wait_q;

	// Sequencer state.
	logic [4:0]  phase_q;
	logic [3:0]  stage_q;
	logic [3:0]  bit_count_q;
	logic [7:0]  shift_byte_q;
	logic [1:0]  byte_index_q;
	logic [15:0] half_counter_q;
	logic [23:0] poll_counter_q;
	logic [15:0] captured_q;
	logic        ack_failed_q;
	logic [19:0] latched_q;

	// Next state.
	logic [4:0]  phase_n;
	logic [3:0]  stage_n;
	logic [3:0]  bit_count_n;
	logic [7:0]  shift_byte_n;
	logic [1:0]  byte_index_n;
	logic [15:0] half_counter_n;
	logic [23:0] poll_counter_n;
	logic [15:0] captured_n;
	logic        ack_failed_n;
	logic [19:0] latched_n;

	// Step helpers.
	logic        accept;
	logic        do_begin;
	logic [3:0]  begin_stage;
	op_t         op_cur;
	op_t         op_begin;
	logic [1:0]  drive_cur;
	logic [1:0]  drive_res;
	logic        busy_res_c;
	logic        done_c;
	logic [15:0] half_eff;
	logic [23:0] poll_eff;
	logic [23:0] poll_inc;
	logic [16:0] half_inc;
	logic [7:0]  rd_shift;
	logic [3:0]  bit_inc;

	// Conversion.
	logic [2:0]         res_flow;
	logic [15:0]        raw_c;
	logic [7:0]         read_byte_c;
	logic [30:0]        product;
	logic [30:0]        rounded;
	logic [14:0]        scaled_c;

	// Result register.
	logic               out_valid_q;
	logic               scl_release_q;
	logic               sda_release_q;
	logic               busy_q;
	logic               done_q;
	logic               ack_fail_q;
	logic [15:0]        raw_value_q;
	logic [7:0]         read_byte_q;
	logic signed [14:0] scaled_q;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign cfg.ready   = 1'b1;

	// A zero period register acts as one.
	assign half_eff = (half_period_q == 16'd0) ? 16'd1 : half_period_q;
	assign poll_eff = (poll_wait_q == 24'd0) ? 24'd1 : poll_wait_q;

	// Sequencer step for one accepted word.
	always_comb begin
		phase_n        = phase_q;
		stage_n        = stage_q;
		bit_count_n    = bit_count_q;
		shift_byte_n   = shift_byte_q;
		byte_index_n   = byte_index_q;
		half_counter_n = half_counter_q;
		poll_counter_n = poll_counter_q;
		captured_n     = captured_q;
		ack_failed_n   = ack_failed_q;
		latched_n      = latched_q;
		done_c         = 1'b0;
		do_begin       = 1'b0;
		begin_stage    = stage_q;
		op_begin       = OP_END;

		op_cur    = script_op(latched_q[2:0], stage_q);
		drive_cur = phase_drive(phase_q, shift_byte_q[7], op_cur);
		poll_inc  = poll_counter_q + 24'd1;
		half_inc  = {1'b0, half_counter_q} + 17'd1;
		rd_shift  = {shift_byte_q[6:0], in_ch.sda_level};
		bit_inc   = bit_count_q + 4'd1;

		if (in_ch.req_type) begin
			// Start request: taken only when idle and the flow is known.
			if (phase_q == PH_IDLE && in_ch.flow <= FLOW_CMD) begin
				latched_n    = {in_ch.quantity, in_ch.write_value, in_ch.command_byte,
					in_ch.flow};
				ack_failed_n   = 1'b0;
				captured_n     = 16'd0;
				byte_index_n   = 2'd0;
				poll_counter_n = 24'd0;
				do_begin       = 1'b1;
				begin_stage    = 4'd0;
			end
		end else if (phase_q == PH_POLL) begin
			// Poll wait before the read address is retried.
			poll_counter_n = poll_inc;
			if (poll_inc >= poll_eff || poll_inc == 24'd0) begin
				do_begin    = 1'b1;
				begin_stage = stage_q + 4'd1;
			end
		end else if (phase_q != PH_IDLE) begin
			if (drive_cur[1] && !in_ch.scl_level) begin
				// Clock held low by the device: the half period stretches.
				half_counter_n = half_counter_q;
			end else if (half_inc < {1'b0, half_eff}) begin
				half_counter_n = half_inc[15:0];
			end else begin
				// End of a half period.
				half_counter_n = 16'd0;
				case (phase_q)
					PH_ST_A: phase_n = PH_ST_B;
					PH_ST_B: phase_n = PH_ST_C;
					PH_ST_C: phase_n = PH_ST_D;
					PH_ST_D: begin
						do_begin    = 1'b1;
						begin_stage = stage_q + 4'd1;
					end
					PH_WB_L: phase_n = PH_WB_H;
					PH_WB_H: begin
						shift_byte_n = {shift_byte_q[6:0], 1'b0};
						bit_count_n  = bit_inc;
						phase_n      = (bit_inc >= 4'd8) ? PH_WA_L : PH_WB_L;
					end
					PH_WA_L: phase_n = PH_WA_H;
					PH_WA_H: begin
						do_begin = 1'b1;
						if (op_cur == OP_RPOLL && in_ch.sda_level) begin
							begin_stage = stage_q - 4'd2;
						end else begin
							if (in_ch.sda_level) begin
								ack_failed_n = 1'b1;
							end
							begin_stage = stage_q + 4'd1;
						end
					end
					PH_RB_L: phase_n = PH_RB_H;
					PH_RB_H: begin
						shift_byte_n = rd_shift;
						bit_count_n  = bit_inc;
						if (bit_inc >= 4'd8) begin
							captured_n   = (byte_index_q != 2'd0) ?
								{captured_q[7:0], rd_shift} : {8'd0, rd_shift};
							byte_index_n = byte_index_q + 2'd1;
							phase_n      = PH_MA_L;
						end else begin
							phase_n = PH_RB_L;
						end
					end
					PH_MA_L: phase_n = PH_MA_H;
					PH_MA_H: begin
						do_begin    = 1'b1;
						begin_stage = stage_q + 4'd1;
					end
					PH_SP_A: phase_n = PH_SP_B;
					PH_SP_B: phase_n = PH_SP_C;
					default: begin
						phase_n = PH_IDLE;
						done_c  = 1'b1;
					end
				endcase
			end
		end

		// Entry into a new script operation.
		if (do_begin) begin
			stage_n        = begin_stage;
			half_counter_n = 16'd0;
			op_begin       = script_op(latched_n[2:0], begin_stage);
			case (op_begin)
				OP_START: phase_n = PH_ST_A;
				OP_WADDR: begin
					shift_byte_n = {bus_address_q, 1'b0};
					bit_count_n  = 4'd0;
					phase_n      = PH_WB_L;
				end
				OP_WCMD: begin
					shift_byte_n = latched_n[10:3];
					bit_count_n  = 4'd0;
					phase_n      = PH_WB_L;
				end
				OP_WVAL: begin
					shift_byte_n = latched_n[18:11];
					bit_count_n  = 4'd0;
					phase_n      = PH_WB_L;
				end
				OP_RADDR, OP_RPOLL: begin
					shift_byte_n = {bus_address_q, 1'b1};
					bit_count_n  = 4'd0;
					phase_n      = PH_WB_L;
				end
				OP_RACK, OP_RNACK: begin
					shift_byte_n = 8'd0;
					bit_count_n  = 4'd0;
					phase_n      = PH_RB_L;
				end
				OP_STOP: phase_n = PH_SP_A;
				OP_WAIT: begin
					poll_counter_n = 24'd0;
					phase_n        = PH_POLL;
				end
				default: phase_n = PH_IDLE;
			endcase
		end

		// A start word shows the drives of the first half period; a tick word
		// shows those of the tick being spent.
		if (in_ch.req_type) begin
			drive_res  = phase_drive(phase_n, shift_byte_n[7],
				script_op(latched_n[2:0], stage_n));
			busy_res_c = (phase_n != PH_IDLE);
		end else begin
			drive_res  = drive_cur;
			busy_res_c = (phase_q != PH_IDLE);
		end
	end

	// Status bits masked off and the reading scaled to hundredths.
	always_comb begin
		res_flow    = latched_n[2:0];
		raw_c       = 16'd0;
		read_byte_c = 8'd0;
		scaled_c    = 15'd0;
		product     = 31'(captured_n & STATUS_MASK) *
			31'(latched_n[19] ? HUM_SCALE : TEMP_SCALE);
		rounded     = product + ROUND_HALF;
		if (res_flow == FLOW_HOLD || res_flow == FLOW_POLLED) begin
			raw_c    = captured_n & STATUS_MASK;
			scaled_c = rounded[30:16] - (latched_n[19] ? HUM_OFFSET : TEMP_OFFSET);
		end else if (res_flow == FLOW_RD_BYTE) begin
			read_byte_c = captured_n[7:0];
		end
	end

	// Configuration writes; an index beyond the registers is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_address_q <= BUS_ADDRESS_RST;
			half_period_q <= HALF_PERIOD_RST;
			poll_wait_q   <= POLL_WAIT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BUS_ADDRESS: bus_address_q <= cfg.data[6:0];
				REG_HALF_PERIOD: half_period_q <= cfg.data[15:0];
				REG_POLL_WAIT:   poll_wait_q   <= cfg.data;
				default:         bus_address_q <= bus_address_q;
			endcase
		end
	end

	// Sequencer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			stage_q        <= 4'd0;
			bit_count_q    <= 4'd0;
			shift_byte_q   <= 8'd0;
			byte_index_q   <= 2'd0;
			half_counter_q <= 16'd0;
			poll_counter_q <= 24'd0;
			captured_q     <= 16'd0;
			ack_failed_q   <= 1'b0;
			latched_q      <= 20'd0;
		end else if (accept) begin
			phase_q        <= phase_n;
			stage_q        <= stage_n;
			bit_count_q    <= bit_count_n;
			shift_byte_q   <= shift_byte_n;
			byte_index_q   <= byte_index_n;
			half_counter_q <= half_counter_n;
			poll_counter_q <= poll_counter_n;
			captured_q     <= captured_n;
			ack_failed_q   <= ack_failed_n;
			latched_q      <= latched_n;
		end
	end

	// Result word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			out_valid_q <= in_ch.valid;
		end
	end

	// Result word payload, loaded with each accepted word.
	always_ff @(posedge clk) begin
		if (accept) begin
			scl_release_q <= drive_res[1];
			sda_release_q <= drive_res[0];
			busy_q        <= busy_res_c;
			done_q        <= done_c;
			ack_fail_q    <= ack_failed_n;
			raw_value_q   <= raw_c;
			read_byte_q   <= read_byte_c;
			scaled_q      <= scaled_c;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.scl_release  = scl_release_q;
	assign out_ch.sda_release  = sda_release_q;
	assign out_ch.busy_res     = busy_q;
	assign out_ch.done_res     = done_q;
	assign out_ch.ack_fail     = ack_fail_q;
	assign out_ch.raw_value    = raw_value_q;
	assign out_ch.read_byte    = read_byte_q;
	assign out_ch.scaled_centi = scaled_q;

endmodule

`default_nettype wire
